### rtl/jrb_pkg.sv
package jrb_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int JIT_W = 35;
	localparam logic [JIT_W-1:0] JITTER_MAX = '1;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_RSVD  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_ACCEPT  = 3'd0,
		ST_LATE    = 3'd1,
		ST_DUP     = 3'd2,
		ST_FRAME   = 3'd3,
		ST_CONCEAL = 3'd4,
		ST_NONE    = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [7:0]  ptype;
		logic [31:0] tstamp;
		logic [15:0] handle;
		logic [15:0] len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		entry_t           hit_entry;
		logic             free;
		logic [IDX_W-1:0] free_idx;
		logic             min;
		logic [IDX_W-1:0] min_idx;
		entry_t           min_entry;
	} scan_res_t;

endpackage

### rtl/jrb_if.sv
interface jrb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  type_byte;
	logic [15:0] sequence_req;
	logic [31:0] timestamp;
	logic [31:0] arrival_ms;
	logic [15:0] payload_handle;
	logic [15:0] payload_length;

	modport source(output valid, kind, type_byte, sequence_req, timestamp, arrival_ms,
		payload_handle, payload_length, input ready);
	modport sink(input valid, kind, type_byte, sequence_req, timestamp, arrival_ms,
		payload_handle, payload_length, output ready);
endinterface

interface jrb_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  out_type_byte;
	logic [15:0] out_sequence;
	logic [31:0] out_timestamp;
	logic [15:0] out_payload_handle;
	logic [15:0] out_payload_length;
	logic [34:0] jitter_q4;
	logic [6:0]  buffered_count;
	logic [31:0] received_count;
	logic [31:0] dropped_count;
	logic [31:0] duplicate_count;
	logic [31:0] lost_count;

	modport source(output valid, status, out_type_byte, out_sequence, out_timestamp,
		out_payload_handle, out_payload_length, jitter_q4, buffered_count, received_count,
		dropped_count, duplicate_count, lost_count, input ready);
	modport sink(input valid, status, out_type_byte, out_sequence, out_timestamp,
		out_payload_handle, out_payload_length, jitter_q4, buffered_count, received_count,
		dropped_count, duplicate_count, lost_count, output ready);
endinterface

### rtl/jrb_entry_ram.sv
module jrb_entry_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 88
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/jrb_scan.sv
module jrb_scan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [15:0]                        key,
	input  logic [jrb_pkg::CAPACITY-1:0]       valid_vec,
	output logic [jrb_pkg::IDX_W-1:0]          rd_addr,
	input  jrb_pkg::entry_t                    rd_data,
	output logic                               done,
	output jrb_pkg::scan_res_t                 res
);
	import jrb_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      key_q;
	logic             cmp_s1;
	logic             last_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             done_q;
	scan_res_t        res_q;

	assign rd_addr = idx_q;
	assign done = done_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			cmp_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
			res_q.hit <= 1'b0;
			res_q.free <= 1'b0;
			res_q.min <= 1'b0;
		end else begin
			cmp_s1 <= busy_q;
			last_s1 <= busy_q && (idx_q == LAST);
			done_q <= cmp_s1 && last_s1;
			if (start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				res_q.hit <= 1'b0;
				res_q.free <= 1'b0;
				res_q.min <= 1'b0;
			end else begin
				if (busy_q) begin
					if (idx_q == LAST) begin
						busy_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				// compare the entry read last cycle
				if (cmp_s1) begin
					if (vld_s1) begin
						if (!res_q.hit && rd_data.seq == key_q) begin
							res_q.hit <= 1'b1;
							res_q.hit_idx <= idx_s1;
							res_q.hit_entry <= rd_data;
						end
						if (!res_q.min || rd_data.seq < res_q.min_entry.seq) begin
							res_q.min <= 1'b1;
							res_q.min_idx <= idx_s1;
							res_q.min_entry <= rd_data;
						end
					end else if (!res_q.free) begin
						res_q.free <= 1'b1;
						res_q.free_idx <= idx_s1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= valid_vec[idx_q];
		idx_s1 <= idx_q;
		if (start) begin
			key_q <= key;
		end
	end
endmodule

### rtl/jrb_jitter.sv
module jrb_jitter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [31:0]                tstamp,
	input  logic [31:0]                arrival,
	input  logic                       upd,
	input  logic                       clr,
	output logic [jrb_pkg::JIT_W-1:0]  jitter
);
	import jrb_pkg::*;

	logic [31:0]      transit_s1;
	logic [31:0]      mag_s2;
	logic [31:0]      prev_q;
	logic [JIT_W-1:0] jitter_q;
	logic [31:0]      delta;
	logic [39:0]      sum;
	logic [35:0]      next_j;

	assign delta = transit_s1 - prev_q;
	// 15*J + 16*|D| + 8, then divide by 16
	assign sum = {1'b0, jitter_q, 4'b0} - {5'b0, jitter_q} + {4'b0, mag_s2, 4'b0} + 40'd8;
	assign next_j = sum[39:4];
	assign jitter = jitter_q;

	always_ff @(posedge clk) begin
		transit_s1 <= arrival - tstamp;
		mag_s2 <= delta[31] ? (32'd0 - delta) : delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			jitter_q <= '0;
		end else if (clr) begin
			jitter_q <= '0;
		end else if (upd) begin
			if (prev_q != 32'd0) begin
				jitter_q <= (next_j > {1'b0, JITTER_MAX}) ? JITTER_MAX : next_j[JIT_W-1:0];
			end
			prev_q <= transit_s1;
		end
	end
endmodule

### rtl/jitter_reorder_buffer_top.sv
// push and pop run a sweep over the entry memory, one entry per cycle, that
// finds the match, a free slot and the minimum; clear and the reserved kind
// skip the sweep; one request is in work at a time
// a finished result waits in the output register while the next request is taken
// asynchronous reset empties the store at once through per-entry valid bits
module jitter_reorder_buffer_top (
	input  logic clk,
	input  logic arst_n,
	jrb_in_if.sink    in_ch,
	jrb_out_if.source out_ch
);
	import jrb_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [7:0]        ptype_q;
	logic [15:0]       seq_q;
	logic [31:0]       ts_q;
	logic [31:0]       arr_q;
	logic [15:0]       handle_q;
	logic [15:0]       len_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]  count_q;
	logic              started_q;
	logic [15:0]       pp_q;
	logic [31:0]       recv_q;
	logic [31:0]       drop_q;
	logic [31:0]       dup_q;
	logic [31:0]       lost_q;
	status_t           res_status_q;
	entry_t            res_entry_q;
	logic              out_valid_q;
	status_t           out_status_q;
	entry_t            out_entry_q;
	logic [JIT_W-1:0]  out_jit_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [31:0]       out_recv_q;
	logic [31:0]       out_drop_q;
	logic [31:0]       out_dup_q;
	logic [31:0]       out_lost_q;

	logic              accept;
	kind_t             in_kind;
	logic              scan_start;
	logic [IDX_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_word;
	logic              scan_done;
	scan_res_t         sres;
	logic [15:0]       diff_push;
	logic [15:0]       diff_pop;
	logic              late;
	logic              dup;
	logic              keep_new;
	logic              is_push_exec;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic              jit_upd;
	logic              jit_clr;
	logic [JIT_W-1:0]  jitter;

	assign in_kind = kind_t'(in_ch.kind);
	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign scan_start = accept && (in_kind == KIND_PUSH || in_kind == KIND_POP);

	assign diff_push = seq_q - pp_q;
	assign diff_pop = sres.min_entry.seq - pp_q;
	assign late = started_q && diff_push[15];
	assign dup = started_q && sres.hit;
	assign keep_new = sres.min && (seq_q >= sres.min_entry.seq);
	assign is_push_exec = (state_q == S_EXEC) && (kind_q == KIND_PUSH) && !late && !dup;
	assign ram_we = is_push_exec && (sres.free || keep_new);
	assign ram_waddr = sres.free ? sres.free_idx : sres.min_idx;
	assign ram_wdata = '{seq: seq_q, ptype: ptype_q, tstamp: ts_q,
		handle: (len_q != 16'd0) ? handle_q : 16'd0, len: len_q};
	assign jit_upd = is_push_exec;
	assign jit_clr = (state_q == S_EXEC) && (kind_q == KIND_CLEAR);

	jrb_entry_ram #(.DEPTH(CAPACITY), .WIDTH(ENTRY_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	jrb_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.key       ((in_kind == KIND_PUSH) ? in_ch.sequence_req : pp_q),
		.valid_vec (valid_q),
		.rd_addr   (rd_addr),
		.rd_data   (entry_t'(rd_word)),
		.done      (scan_done),
		.res       (sres)
	);

	jrb_jitter u_jitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.tstamp  (ts_q),
		.arrival (arr_q),
		.upd     (jit_upd),
		.clr     (jit_clr),
		.jitter  (jitter)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			ptype_q <= in_ch.type_byte;
			seq_q <= in_ch.sequence_req;
			ts_q <= in_ch.timestamp;
			arr_q <= in_ch.arrival_ms;
			handle_q <= in_ch.payload_handle;
			len_q <= in_ch.payload_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			started_q <= 1'b0;
			pp_q <= '0;
			recv_q <= '0;
			drop_q <= '0;
			dup_q <= '0;
			lost_q <= '0;
			res_status_q <= ST_NONE;
			res_entry_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= ST_NONE;
			out_entry_q <= '0;
			out_jit_q <= '0;
			out_count_q <= '0;
			out_recv_q <= '0;
			out_drop_q <= '0;
			out_dup_q <= '0;
			out_lost_q <= '0;
		end else begin
			// in S_OUT the output register is reloaded below instead
			if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (scan_start) begin
						state_q <= S_SCAN;
					end else if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					case (kind_q)
						KIND_PUSH: begin
							recv_q <= recv_q + 32'd1;
							res_entry_q <= '0;
							if (late) begin
								drop_q <= drop_q + 32'd1;
								res_status_q <= ST_LATE;
							end else if (dup) begin
								dup_q <= dup_q + 32'd1;
								res_status_q <= ST_DUP;
							end else begin
								res_status_q <= ST_ACCEPT;
								if (!started_q) begin
									started_q <= 1'b1;
									pp_q <= seq_q;
								end
								if (sres.free) begin
									valid_q[sres.free_idx] <= 1'b1;
									count_q <= count_q + 1'b1;
								end else begin
									// store full: the smallest sequence is replaced unless the new one is smaller, which is then dropped
									drop_q <= drop_q + 32'd1;
								end
							end
						end
						KIND_POP: begin
							if (started_q && sres.hit) begin
								res_status_q <= ST_FRAME;
								res_entry_q <= sres.hit_entry;
								valid_q[sres.hit_idx] <= 1'b0;
								count_q <= count_q - 1'b1;
								pp_q <= pp_q + 16'd1;
							end else if (started_q && sres.min && diff_pop != 16'd0
								&& !diff_pop[15]) begin
								res_status_q <= ST_CONCEAL;
								res_entry_q <= '{seq: pp_q, ptype: sres.min_entry.ptype,
									tstamp: 32'd0, handle: 16'd0, len: 16'd0};
								pp_q <= pp_q + 16'd1;
								lost_q <= lost_q + 32'd1;
							end else begin
								res_status_q <= ST_NONE;
								res_entry_q <= '0;
							end
						end
						KIND_CLEAR: begin
							res_status_q <= ST_CLEARED;
							res_entry_q <= '0;
							valid_q <= '0;
							count_q <= '0;
							started_q <= 1'b0;
							pp_q <= '0;
							recv_q <= '0;
							drop_q <= '0;
							dup_q <= '0;
							lost_q <= '0;
						end
						default: begin
							res_status_q <= ST_NONE;
							res_entry_q <= '0;
						end
					endcase
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_entry_q <= res_entry_q;
						out_jit_q <= jitter;
						out_count_q <= count_q;
						out_recv_q <= recv_q;
						out_drop_q <= drop_q;
						out_dup_q <= dup_q;
						out_lost_q <= lost_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = out_status_q;
	assign out_ch.out_type_byte = out_entry_q.ptype;
	assign out_ch.out_sequence = out_entry_q.seq;
	assign out_ch.out_timestamp = out_entry_q.tstamp;
	assign out_ch.out_payload_handle = out_entry_q.handle;
	assign out_ch.out_payload_length = out_entry_q.len;
	assign out_ch.jitter_q4 = out_jit_q;
	assign out_ch.buffered_count = 7'(out_count_q);
	assign out_ch.received_count = out_recv_q;
	assign out_ch.dropped_count = out_drop_q;
	assign out_ch.duplicate_count = out_dup_q;
	assign out_ch.lost_count = out_lost_q;
endmodule

### rtl/jrb_checker.sv
module jrb_props (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [31:0] out_timestamp,
	input logic [15:0] out_payload_length,
	input logic [34:0] jitter_q4,
	input logic [6:0]  buffered_count,
	input logic [31:0] received_count
);
	import jrb_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> buffered_count <= 7'(CAPACITY))
		else $error("buffered count beyond capacity");

	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(ST_FRAME) && status != 3'(ST_CONCEAL)
		|-> out_timestamp == 32'd0 && out_payload_length == 16'd0)
		else $error("frame fields set on a non-frame result");

	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == 3'(ST_CLEARED)
		|-> buffered_count == 7'd0 && received_count == 32'd0 && jitter_q4 == 35'd0)
		else $error("state left after clear");
endmodule

bind jitter_reorder_buffer_top jrb_props u_jrb_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_ch.valid),
	.out_ready          (out_ch.ready),
	.status             (out_ch.status),
	.out_timestamp      (out_ch.out_timestamp),
	.out_payload_length (out_ch.out_payload_length),
	.jitter_q4          (out_ch.jitter_q4),
	.buffered_count     (out_ch.buffered_count),
	.received_count     (out_ch.received_count)
);

### tb/jrb_checker.sv
`timescale 1ns / 1ps
module jrb_checker (
	input  logic clk,
	input  logic arst_n,
	jrb_in_if  in_ch,
	jrb_out_if out_ch,
	output int fail_count,
	output int pending,
	output int frames_seen,
	output int conceal_seen,
	output int evict_seen
);
	import jrb_pkg::*;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  ptype;
		logic [15:0] seq;
		logic [31:0] tstamp;
		logic [15:0] handle;
		logic [15:0] len;
		logic [34:0] jitter;
		logic [6:0]  held;
		logic [31:0] rcv, drp, dup, lost;
	} answer_t;

	answer_t answers[$];

	logic        held_valid[CAPACITY];
	entry_t      held_entry[CAPACITY];
	logic        started;
	logic [15:0] playout;
	logic [31:0] prev_transit;
	logic [35:0] jitter;
	logic [31:0] n_rcv, n_drp, n_dup, n_lost;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic int lookup(input logic [15:0] s);
		for (int i = 0; i < CAPACITY; i++)
			if (held_valid[i] && held_entry[i].seq == s)
				return i;
		return -1;
	endfunction

	function automatic int oldest_raw();
		int b;
		b = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (held_valid[i] && (b < 0 || held_entry[i].seq < held_entry[b].seq))
				b = i;
		return b;
	endfunction

	task automatic wipe();
		for (int i = 0; i < CAPACITY; i++)
			held_valid[i] = 0;
		started = 0;
		playout = '0;
		jitter = '0;
		n_rcv = 0; n_drp = 0; n_dup = 0; n_lost = 0;
	endtask

	task automatic predict_request();
		answer_t a;
		int slot, m;
		logic [15:0] d16;
		logic [31:0] transit, dt, mag;
		logic [39:0] nj;
		a = '{default: '0};
		a.status = ST_NONE;
		case (kind_t'(in_ch.kind))
			KIND_PUSH: begin
				a.status = ST_ACCEPT;
				n_rcv++;
				d16 = in_ch.sequence_req - playout;
				if (started && d16[15]) begin
					n_drp++;
					a.status = ST_LATE;
				end else if (started && lookup(in_ch.sequence_req) >= 0) begin
					n_dup++;
					a.status = ST_DUP;
				end else begin
					if (!started) begin
						started = 1;
						playout = in_ch.sequence_req;
					end
					transit = in_ch.arrival_ms - in_ch.timestamp;
					if (prev_transit != 0) begin
						dt = transit - prev_transit;
						mag = dt[31] ? -dt : dt;
						nj = (40'(jitter) * 15 + (40'(mag) << 4) + 8) >> 4;
						jitter = (nj > 40'(JITTER_MAX)) ? 36'(JITTER_MAX) : nj[35:0];
					end
					prev_transit = transit;
					slot = -1;
					for (int i = 0; i < CAPACITY; i++)
						if (slot < 0 && !held_valid[i])
							slot = i;
					if (slot < 0) begin
						m = oldest_raw();
						n_drp++;
						evict_seen++;
						if (in_ch.sequence_req >= held_entry[m].seq)
							slot = m;
					end
					if (slot >= 0) begin
						held_valid[slot] = 1;
						held_entry[slot].seq = in_ch.sequence_req;
						held_entry[slot].ptype = in_ch.type_byte;
						held_entry[slot].tstamp = in_ch.timestamp;
						held_entry[slot].len = in_ch.payload_length;
						held_entry[slot].handle =
							(in_ch.payload_length != 0) ? in_ch.payload_handle : '0;
					end
				end
			end
			KIND_POP: if (started) begin
				slot = lookup(playout);
				if (slot >= 0) begin
					a.status = ST_FRAME;
					a.ptype = held_entry[slot].ptype;
					a.seq = held_entry[slot].seq;
					a.tstamp = held_entry[slot].tstamp;
					a.handle = held_entry[slot].handle;
					a.len = held_entry[slot].len;
					held_valid[slot] = 0;
					playout++;
					frames_seen++;
				end else begin
					m = oldest_raw();
					if (m >= 0) begin
						d16 = held_entry[m].seq - playout;
						if (d16 != 0 && !d16[15]) begin
							a.status = ST_CONCEAL;
							a.ptype = held_entry[m].ptype;
							a.seq = playout;
							playout++;
							n_lost++;
							conceal_seen++;
						end
					end
				end
			end
			KIND_CLEAR: begin
				wipe();
				a.status = ST_CLEARED;
			end
			default: ;
		endcase
		a.jitter = jitter[34:0];
		a.held = 0;
		for (int i = 0; i < CAPACITY; i++)
			a.held += held_valid[i];
		a.rcv = n_rcv; a.drp = n_drp; a.dup = n_dup; a.lost = n_lost;
		answers.push_back(a);
	endtask

	task automatic compare_result();
		answer_t w;
		if (answers.size() == 0) begin
			report("unexpected result", out_ch.status, 0);
			return;
		end
		w = answers.pop_front();
		if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
		if (out_ch.out_type_byte !== w.ptype) report("type", out_ch.out_type_byte, w.ptype);
		if (out_ch.out_sequence !== w.seq) report("sequence", out_ch.out_sequence, w.seq);
		if (out_ch.out_timestamp !== w.tstamp)
			report("timestamp", out_ch.out_timestamp, w.tstamp);
		if (out_ch.out_payload_handle !== w.handle)
			report("handle", out_ch.out_payload_handle, w.handle);
		if (out_ch.out_payload_length !== w.len)
			report("length", out_ch.out_payload_length, w.len);
		if (out_ch.jitter_q4 !== w.jitter) report("jitter", out_ch.jitter_q4, w.jitter);
		if (out_ch.buffered_count !== w.held) report("buffered", out_ch.buffered_count, w.held);
		if (out_ch.received_count !== w.rcv) report("received", out_ch.received_count, w.rcv);
		if (out_ch.dropped_count !== w.drp) report("dropped", out_ch.dropped_count, w.drp);
		if (out_ch.duplicate_count !== w.dup)
			report("duplicate", out_ch.duplicate_count, w.dup);
		if (out_ch.lost_count !== w.lost) report("lost", out_ch.lost_count, w.lost);
	endtask

	initial begin
		fail_count = 0;
		frames_seen = 0;
		conceal_seen = 0;
		evict_seen = 0;
		prev_transit = 0;
		wipe();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				compare_result();
			if (in_ch.valid && in_ch.ready)
				predict_request();
		end
		pending <= answers.size();
	end

	final if (answers.size() != 0) $display("%0d results never arrived", answers.size());

endmodule

### tb/tb_jitter_reorder_buffer_top.sv
`timescale 1ns / 1ps
module tb_jitter_reorder_buffer_top;
	import jrb_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count, pending, frames_seen, conceal_seen, evict_seen;
	int   send_idle, recv_stall;
	int   hold_cycles = 0;
	logic hold_go;
	logic hold_taken = 1'b0;
	int   accepted;
	logic [15:0] base_seq;
	logic [31:0] clock_ms;

	jrb_in_if  in_ch();
	jrb_out_if out_ch();

	jitter_reorder_buffer_top u_top (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	jrb_checker u_chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending), .frames_seen(frames_seen),
		.conceal_seen(conceal_seen), .evict_seen(evict_seen)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("FAIL jitter_reorder_buffer_top");
		$finish;
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 3000;
			out_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send(input kind_t k, input logic [7:0] pt, input logic [15:0] s,
		input logic [31:0] ts, input logic [31:0] arr, input logic [15:0] h,
		input logic [15:0] len);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.type_byte <= pt;
		in_ch.sequence_req <= s;
		in_ch.timestamp <= ts;
		in_ch.arrival_ms <= arr;
		in_ch.payload_handle <= h;
		in_ch.payload_length <= len;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		accepted++;
	endtask

	task automatic push(input logic [15:0] s, input logic [31:0] ts, input logic [31:0] arr);
		send(KIND_PUSH, 8'($urandom), s, ts, arr, 16'($urandom),
			($urandom_range(7) == 0) ? 16'd0 : 16'($urandom));
	endtask

	task automatic pop();
		send(KIND_POP, 8'($urandom), 16'($urandom), $urandom, $urandom, 16'($urandom),
			16'($urandom));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (CAPACITY + 10) @(posedge clk);
	endtask

	// mostly in-order pushes with reordering, loss, late, dups; also pops, clears, rsvd
	task automatic stream(input int n);
		int r;
		logic [15:0] s;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			clock_ms += $urandom_range(40);
			if (r < 55) begin
				s = base_seq + 16'($urandom_range(3));
				if ($urandom_range(9) == 0) base_seq += 2;
				else base_seq++;
				push(s, clock_ms - 20 - $urandom_range(30), clock_ms);
			end else if (r < 62) begin
				push(base_seq - 16'($urandom_range(1, 6)), clock_ms - 20, clock_ms);
			end else if (r < 92) begin
				pop();
			end else if (r < 94) begin
				send(KIND_CLEAR, '0, '0, '0, '0, '0, '0);
			end else if (r < 96) begin
				send(KIND_RSVD, 8'($urandom), 16'($urandom), $urandom, $urandom,
					16'($urandom), 16'($urandom));
			end else begin
				push(16'($urandom), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_PUSH;
		in_ch.type_byte = '0;
		in_ch.sequence_req = '0;
		in_ch.timestamp = '0;
		in_ch.arrival_ms = '0;
		in_ch.payload_handle = '0;
		in_ch.payload_length = '0;
		hold_go = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		accepted = 0;
		clock_ms = 32'd1000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop before start, reserved kind, field extremes, wrap, late, dup, conceal
		pop();
		send(KIND_RSVD, 8'hFF, 16'hFFFF, '1, '1, '1, '1);
		send(KIND_PUSH, 8'hFF, 16'hFFFE, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send(KIND_PUSH, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0000);
		send(KIND_PUSH, 8'hA5, 16'h0001, 32'h8000_0000, 32'h0000_0010, 16'h1234, 16'h0040);
		send(KIND_PUSH, 8'h5A, 16'h0001, 32'h0, 32'h5, 16'h0, 16'h1);
		send(KIND_PUSH, 8'h11, 16'hFFFD, 32'h0, 32'h5, 16'h0, 16'h1);
		pop(); pop(); pop(); pop(); pop(); pop();
		send(KIND_PUSH, 8'h33, 16'h7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h8000);
		send(KIND_CLEAR, '0, '0, '0, '0, '0, '0);
		pop();
		send(KIND_PUSH, 8'h01, 16'h0000, 32'h0, 32'h0, 16'h0001, 16'h0001);
		send(KIND_PUSH, 8'h02, 16'h8000, 32'h1, 32'h7FFF_FFFF, 16'h0002, 16'h0002);
		pop(); pop();
		send(KIND_CLEAR, '0, '0, '0, '0, '0, '0);
		drain();

		// fill past capacity while the receiver holds off, then evict
		base_seq = 16'd100;
		hold_go <= 1'b1;
		for (int i = 0; i < CAPACITY + 6; i++)
			push(base_seq + 16'(i), clock_ms, clock_ms + i * 3);
		push(16'd90 + 16'd200, clock_ms, clock_ms);
		drain();
		send(KIND_CLEAR, '0, '0, '0, '0, '0, '0);

		base_seq = 16'($urandom);
		stream(260);
		send_idle = 62; stream(260);
		send_idle = 0; recv_stall = 62; stream(260);
		send_idle = 32; recv_stall = 32; stream(260);
		drain();

		$display("%0d requests sent: %0d frames, %0d concealments, %0d capacity evictions",
			accepted, frames_seen, conceal_seen, evict_seen);
		if (fail_count == 0)
			$display("PASS jitter_reorder_buffer_top");
		else
			$display("FAIL jitter_reorder_buffer_top");
		$finish;
	end

endmodule
